/* hw/rtl/rptsp_pkg.sv */
// Package for the stride prefetcher: widths, register indexes, controller states,
// and the command and status structs between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps
package rptsp_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;

  localparam int ADDR_W  = 32;
  localparam int BLOCK_W = 13;
  localparam int REQS_W  = 5;
  localparam int REM_W   = 4;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REQS_PER_MISS    = 2'd2;

  localparam logic [BLOCK_W-1:0] BLOCK_SIZE_RST = 13'd64;
  localparam logic [REQS_W-1:0]  REQS_RST       = 5'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REM,
    ST_READ,
    ST_CALC,
    ST_UPD,
    ST_OUT
  } ctl_state_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic rem_step;
    logic rd;
    logic calc;
    logic upd;
    logic cap;
  } dp_cmd_t;

  typedef struct packed {
    logic miss_go;
    logic comp_go;
    logic rem_done;
    logic clr_last;
  } dp_stat_t;

  // requests left after the first one: clamp to 1..16, minus one
  function automatic logic [REM_W-1:0] init_remaining(input logic [REQS_W-1:0] reqs);
    logic [REM_W-1:0] r;
    if (reqs == '0) begin
      r = '0;
    end else if (reqs > 5'd16) begin
      r = 4'hf;
    end else begin
      r = REM_W'(reqs - 5'd1);
    end
    return r;
  endfunction

endpackage

/* hw/rtl/rptsp_if.sv */
// Handshake channels of the stride prefetcher: access/completion requests in,
// prefetch state out. Depends on rptsp_pkg for widths.
`timescale 1ns / 1ps
interface rptsp_req_if import rptsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [ADDR_W-1:0] access_pc;
  logic [ADDR_W-1:0] access_addr;
  logic              l1_hit;

  modport source (output valid, action, access_pc, access_addr, l1_hit, input ready);
  modport sink   (input valid, action, access_pc, access_addr, l1_hit, output ready);
endinterface

interface rptsp_rsp_if import rptsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              prefetch_valid;
  logic [ADDR_W-1:0] prefetch_addr;

  modport source (output valid, prefetch_valid, prefetch_addr, input ready);
  modport sink   (input valid, prefetch_valid, prefetch_addr, output ready);
endinterface

/* hw/rtl/rptsp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module rptsp_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* hw/rtl/rptsp_datapath.sv */
// Datapath: config registers, pc-to-slot remainder unit, table RAM and the
// prefetch run state. Depends on rptsp_pkg and rptsp_ram.
`timescale 1ns / 1ps
module rptsp_datapath import rptsp_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 req_action,
  input  logic [ADDR_W-1:0]    req_pc,
  input  logic [ADDR_W-1:0]    req_addr,
  input  logic                 req_hit,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  output logic                 prefetch_valid,
  output logic [ADDR_W-1:0]    prefetch_addr
);
  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int EW = 3 * ADDR_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);
  localparam bit IS_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);

  logic [BLOCK_W-1:0]       block_size;
  logic signed [ADDR_W-1:0] stride_thr;
  logic [REQS_W-1:0]        reqs_per_miss;

  logic              pending;
  logic [ADDR_W-1:0] next_addr;
  logic [REM_W-1:0]  remaining;
  logic [AW-1:0]     trig_idx;

  logic              rsp_pf_valid;
  logic [ADDR_W-1:0] rsp_pf_addr;

  logic              is_miss;
  logic [ADDR_W-1:0] pc_l;
  logic [ADDR_W-1:0] addr_l;
  logic [AW-1:0]     cur_idx;
  logic [AW-1:0]     mod_idx;
  logic [AW-1:0]     clr_cnt;
  logic [ADDR_W-1:0] stride;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [EW-1:0]     ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [EW-1:0]     ram_rdata;
  logic [ADDR_W-1:0] s_pc;
  logic [ADDR_W-1:0] s_stride;
  logic [ADDR_W-1:0] s_last;
  logic [ADDR_W-1:0] block_ext;

  logic              pc_match;
  logic              use_stride;
  logic [ADDR_W-1:0] miss_next;
  logic [ADDR_W-1:0] miss_stride;
  logic [ADDR_W-1:0] comp_next;

  assign {s_pc, s_stride, s_last} = ram_rdata;
  assign block_ext = ADDR_W'(block_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size    <= BLOCK_SIZE_RST;
      stride_thr    <= '0;
      reqs_per_miss <= REQS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCK_SIZE:       block_size    <= cfg_data[BLOCK_W-1:0];
        REG_STRIDE_THRESHOLD: stride_thr    <= $signed(cfg_data[ADDR_W-1:0]);
        REG_REQS_PER_MISS:    reqs_per_miss <= cfg_data[REQS_W-1:0];
        default: ;
      endcase
    end
  end

  // slot index = pc mod TABLE_ENTRIES
  generate
    if (IS_POW2 && TABLE_ENTRIES == 1) begin : g_one
      assign mod_idx       = '0;
      assign stat.rem_done = 1'b1;
    end else if (IS_POW2) begin : g_mask
      assign mod_idx       = pc_l[AW-1:0];
      assign stat.rem_done = 1'b1;
    end else begin : g_div
      // quotient by reciprocal multiply, then remainder = pc - q * N
      localparam int SH = ADDR_W + AW;
      localparam int PW = 2 * ADDR_W + 1;
      localparam logic [ADDR_W:0] RECIP = (ADDR_W + 1)'(
        ((64'd1 << SH) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES));
      logic [PW-1:0]     m_prod;
      logic [ADDR_W-1:0] m_q;
      logic [ADDR_W-1:0] m_qn;
      logic [AW-1:0]     m_r;
      logic [1:0]        m_cnt;

      assign m_prod = PW'(pc_l) * PW'(RECIP);
      assign m_qn   = m_q * ADDR_W'(TABLE_ENTRIES);

      always_ff @(posedge clk) begin
        if (cmd.load) begin
          m_cnt <= '0;
        end else if (cmd.rem_step && m_cnt != 2'd2) begin
          if (m_cnt == 2'd0) begin
            m_q <= ADDR_W'(m_prod >> SH);
          end else begin
            m_r <= AW'(pc_l - m_qn);
          end
          m_cnt <= m_cnt + 2'd1;
        end
      end

      assign mod_idx       = m_r;
      assign stat.rem_done = (m_cnt == 2'd2);
    end
  endgenerate

  assign stat.miss_go  = !req_action && !pending && !req_hit;
  assign stat.comp_go  = req_action && (remaining != '0);
  assign stat.clr_last = (clr_cnt == LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr && clr_cnt != LAST_IDX) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_miss <= stat.miss_go;
      pc_l    <= req_pc;
      addr_l  <= req_addr;
    end
    if (cmd.rd) begin
      cur_idx <= ram_raddr;
    end
    if (cmd.calc) begin
      stride <= addr_l - s_last;
    end
  end

  assign ram_raddr = is_miss ? mod_idx : trig_idx;

  assign pc_match    = (s_pc == pc_l);
  assign use_stride  = pc_match && (stride == s_stride) && ($signed(stride) > stride_thr);
  assign miss_next   = addr_l + (use_stride ? stride : block_ext);
  assign miss_stride = !pc_match ? '0 : (use_stride ? s_stride : stride);
  assign comp_next   = next_addr + ((s_stride != '0) ? s_stride : block_ext);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_idx;
    ram_wdata = {pc_l, miss_stride, addr_l};
    if (cmd.clr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = '0;
    end else if (cmd.upd) begin
      if (is_miss) begin
        ram_we = 1'b1;
      end else if (s_stride != '0) begin
        ram_we    = 1'b1;
        ram_wdata = {s_pc, s_stride, comp_next};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 1'b0;
      next_addr <= '0;
      remaining <= '0;
      trig_idx  <= '0;
    end else if (cmd.load) begin
      if (req_action && remaining == '0) begin
        pending <= 1'b0;
      end
    end else if (cmd.upd) begin
      if (is_miss) begin
        pending   <= 1'b1;
        next_addr <= miss_next;
        remaining <= init_remaining(reqs_per_miss);
        trig_idx  <= cur_idx;
      end else begin
        next_addr <= comp_next;
        remaining <= remaining - REM_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_pf_valid <= 1'b0;
      rsp_pf_addr  <= '0;
    end else if (cmd.cap) begin
      rsp_pf_valid <= pending;
      rsp_pf_addr  <= pending ? next_addr : '0;
    end
  end

  assign prefetch_valid = rsp_pf_valid;
  assign prefetch_addr  = rsp_pf_addr;

  rptsp_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );
endmodule

/* hw/rtl/rptsp_ctrl.sv */
// Controller state machine: clearing pass, request intake, table lookup
// sequence and result handoff. Depends on rptsp_pkg.
`timescale 1ns / 1ps
module rptsp_ctrl import rptsp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);
  ctl_state_t state;
  ctl_state_t state_next;
  logic       rsp_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // result register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_full <= 1'b0;
    end else if (cmd.cap) begin
      rsp_full <= 1'b1;
    end else if (rsp_ready) begin
      rsp_full <= 1'b0;
    end
  end

  assign rsp_valid = rsp_full;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (stat.clr_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (req_valid) begin
          if (stat.miss_go) begin
            state_next = ST_REM;
          end else if (stat.comp_go) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_REM:  if (stat.rem_done) state_next = ST_READ;
      ST_READ: state_next = ST_CALC;
      ST_CALC: state_next = ST_UPD;
      ST_UPD:  state_next = ST_OUT;
      ST_OUT:  if (!rsp_full || rsp_ready) state_next = ST_IDLE;
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      ST_CLEAR: cmd.clr = 1'b1;
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      ST_REM: begin
        cmd.rem_step = 1'b1;
        cmd.rd       = stat.rem_done;
      end
      // completions read the trigger slot here; a miss rereads its own slot
      ST_READ: cmd.rd = 1'b1;
      ST_CALC: cmd.calc = 1'b1;
      ST_UPD:  cmd.upd = 1'b1;
      ST_OUT:  cmd.cap = !rsp_full || rsp_ready;
      default: ;
    endcase
  end
endmodule

/* hw/rtl/rpt_stride_prefetcher_core.sv */
// Top level of the reference-prediction-table stride prefetcher.
// Depends on rptsp_pkg, rptsp_if, rptsp_ctrl, rptsp_datapath, rptsp_ram.
//
//   channel   dir  handshake         payload
//   req       in   valid / ready     action, access_pc, access_addr, l1_hit
//   rsp       out  valid / ready     prefetch_valid, prefetch_addr
//   cfg       in   cfg_we            cfg_index, cfg_data
//
// One request at a time, intake to result capture: a hit, busy access or idle
// completion goes straight to ST_OUT; an advancing completion passes ST_READ, ST_CALC
// and ST_UPD; a miss adds ST_REM (two-step reciprocal multiply unless power of two).
// The result shows on rsp from a register the cycle after capture; a second
// result waits in ST_OUT while that register is full.
// After reset a clearing pass writes TABLE_ENTRIES rows, one per cycle, req.ready low.
`timescale 1ns / 1ps
module rpt_stride_prefetcher_core import rptsp_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  rptsp_req_if.sink            req,
  rptsp_rsp_if.source          rsp
);
  dp_cmd_t  cmd;
  dp_stat_t stat;

  rptsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rptsp_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .req_action     (req.action),
    .req_pc         (req.access_pc),
    .req_addr       (req.access_addr),
    .req_hit        (req.l1_hit),
    .cmd            (cmd),
    .stat           (stat),
    .prefetch_valid (rsp.prefetch_valid),
    .prefetch_addr  (rsp.prefetch_addr)
  );
endmodule

/* tb/rpt_stride_prefetcher_core_tb.sv */
// Self-checking testbench for rpt_stride_prefetcher_core: a directed table and then
// phases of random access/completion traffic checked against an in-bench model.
// Depends on rptsp_pkg, the rptsp_req_if/rptsp_rsp_if channels and the core RTL.
`timescale 1ns / 1ps
module rpt_stride_prefetcher_core_tb;
  import rptsp_pkg::*;

  localparam logic ACT_ACCESS = 1'b0;
  localparam logic ACT_DONE   = 1'b1;

  localparam int N_PHASES     = 9;
  localparam int PHASE_ITEMS  = 140;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 8;
  localparam int QUIET_LIMIT  = 3000;
  localparam int N_STREAMS    = 10;
  localparam int N_DIRECTED   = 25;

  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] pc;
    logic [ADDR_W-1:0] addr;
    logic              hit;
  } pf_req_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
  } pf_rsp_t;

  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] pc;
    logic [ADDR_W-1:0] addr;
    logic              hit;
    logic              typed;
    logic              want_v;
    logic [ADDR_W-1:0] want_a;
  } dir_row_t;

  // action, pc, addr, hit, typed, expected valid, expected address
  localparam dir_row_t DIR_ROWS [N_DIRECTED] = '{
    '{ACT_DONE,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 32'h0000_0000},
    '{ACT_ACCESS, 32'h0000_0110, 32'h0000_2000, 1'b1, 1'b1, 1'b0, 32'h0000_0000},
    '{ACT_ACCESS, 32'h0000_0010, 32'h0000_1000, 1'b0, 1'b1, 1'b1, 32'h0000_1040},
    '{ACT_ACCESS, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 1'b1, 1'b1, 32'h0000_1040},
    '{ACT_DONE,   32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b1, 1'b1, 32'h0000_1080},
    '{ACT_DONE,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 32'h0000_10c0},
    '{ACT_DONE,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 32'h0000_1100},
    '{ACT_DONE,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 32'h0000_0000},
    '{ACT_ACCESS, 32'h0000_0010, 32'h0000_1100, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{ACT_DONE,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{ACT_DONE,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{ACT_DONE,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{ACT_DONE,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{ACT_ACCESS, 32'h0000_0010, 32'h0000_1540, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{ACT_DONE,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{ACT_DONE,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{ACT_DONE,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{ACT_DONE,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{ACT_ACCESS, 32'h0000_0110, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{ACT_DONE,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{ACT_DONE,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{ACT_DONE,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{ACT_DONE,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0000_0000},
    '{ACT_ACCESS, 32'hffff_ffff, 32'hffff_fff0, 1'b0, 1'b1, 1'b1, 32'h0000_0030},
    '{ACT_DONE,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0000_0000}
  };

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  rptsp_req_if req ();
  rptsp_rsp_if rsp ();

  rpt_stride_prefetcher_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req      (req),
    .rsp      (rsp)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // prefetcher model state
  logic [ADDR_W-1:0]       tbl_pc     [TABLE_ENTRIES_DEF];
  logic [ADDR_W-1:0]       tbl_stride [TABLE_ENTRIES_DEF];
  logic [ADDR_W-1:0]       tbl_last   [TABLE_ENTRIES_DEF];
  logic                    pf_busy;
  logic [ADDR_W-1:0]       pf_addr;
  logic [REM_W-1:0]        pf_left;
  logic [ADDR_W-1:0]       pf_trigger;
  logic [BLOCK_W-1:0]      blk_reg;
  logic signed [ADDR_W-1:0] thr_reg;
  logic [REQS_W-1:0]       reqs_reg;

  pf_rsp_t           due_prefetch_q [$];
  logic [ADDR_W-1:0] pc_pool [N_STREAMS];
  int                send_pct;
  int                stall_pct = 0;
  int                hold_seq = 0;
  int                hold_seen = 0;
  int                hold_left = 0;
  int                quiet_cycles = 0;
  int                errors = 0;
  int                n_requests = 0;
  int                n_checked = 0;
  int                n_armed = 0;
  int                n_stride_hits = 0;
  int                n_advances = 0;

  task automatic advance_prefetcher(input pf_req_t rq, output pf_rsp_t res);
    int unsigned       idx;
    logic [ADDR_W-1:0] st;
    if (rq.action == ACT_ACCESS) begin
      if (!pf_busy && !rq.hit) begin
        idx = rq.pc % TABLE_ENTRIES_DEF;
        if (tbl_pc[idx] == rq.pc) begin
          st = rq.addr - tbl_last[idx];
          if (st == tbl_stride[idx] && $signed(st) > thr_reg) begin
            pf_addr = rq.addr + st;
            n_stride_hits++;
          end else begin
            tbl_stride[idx] = st;
            pf_addr = rq.addr + ADDR_W'(blk_reg);
          end
        end else begin
          pf_addr = rq.addr + ADDR_W'(blk_reg);
          tbl_stride[idx] = '0;
        end
        pf_busy = 1'b1;
        if (reqs_reg == '0) begin
          pf_left = '0;
        end else if (reqs_reg > 5'd16) begin
          pf_left = 4'hf;
        end else begin
          pf_left = REM_W'(reqs_reg - 5'd1);
        end
        pf_trigger = rq.pc;
        tbl_pc[idx] = rq.pc;
        tbl_last[idx] = rq.addr;
        n_armed++;
      end
    end else if (pf_left == '0) begin
      pf_busy = 1'b0;
    end else begin
      pf_left = pf_left - 1'b1;
      idx = pf_trigger % TABLE_ENTRIES_DEF;
      if (tbl_stride[idx] != '0) begin
        pf_addr = pf_addr + tbl_stride[idx];
        tbl_last[idx] = pf_addr;
      end else begin
        pf_addr = pf_addr + ADDR_W'(blk_reg);
      end
      n_advances++;
    end
    res.valid = pf_busy;
    res.addr  = pf_busy ? pf_addr : '0;
  endtask

  // drive one request, wait for it to be taken, then record what it should produce
  task automatic issue_request(input pf_req_t rq, input logic typed, input pf_rsp_t want);
    pf_rsp_t pred;
    while (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.action      <= rq.action;
    req.access_pc   <= rq.pc;
    req.access_addr <= rq.addr;
    req.l1_hit      <= rq.hit;
    do @(posedge clk); while (!req.ready);
    advance_prefetcher(rq, pred);
    due_prefetch_q.push_back(typed ? want : pred);
    n_requests++;
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (due_prefetch_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_regs(input logic [BLOCK_W-1:0] bs, input logic signed [31:0] thr,
                              input logic [REQS_W-1:0] nreq);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BLOCK_SIZE;
    cfg_data  <= CFG_W'(bs);
    @(posedge clk);
    cfg_index <= REG_STRIDE_THRESHOLD;
    cfg_data  <= thr;
    @(posedge clk);
    cfg_index <= REG_REQS_PER_MISS;
    cfg_data  <= CFG_W'(nreq);
    @(posedge clk);
    cfg_we  <= 1'b0;
    blk_reg  = bs;
    thr_reg  = thr;
    reqs_reg = nreq;
  endtask

  // mostly well-formed miss + completion runs on a pool of pcs, some noise
  task automatic run_traffic(input int n_items);
    int                done_items;
    int                roll;
    int                s;
    int                eff;
    int                n_comp;
    int unsigned       idx;
    logic [ADDR_W-1:0] st;
    pf_req_t           rq;
    done_items = 0;
    while (done_items < n_items) begin
      roll = $urandom_range(0, 99);
      s = $urandom_range(0, N_STREAMS - 1);
      if (roll < 10) begin
        rq = '{1'($urandom_range(0, 1)), $urandom, $urandom, 1'($urandom_range(0, 1))};
        issue_request(rq, 1'b0, '0);
        if (rq.action == ACT_DONE || !rq.hit) done_items++;
      end else if (roll < 18) begin
        rq = '{ACT_ACCESS, pc_pool[s], $urandom, 1'b1};
        issue_request(rq, 1'b0, '0);
      end else begin
        idx = pc_pool[s] % TABLE_ENTRIES_DEF;
        if (tbl_pc[idx] == pc_pool[s] && tbl_stride[idx] != '0 && $urandom_range(0, 99) < 55) begin
          st = tbl_stride[idx];
        end else begin
          case ($urandom_range(0, 7))
            0: st = '0;
            1: st = thr_reg;
            2: st = thr_reg + 1;
            3: st = $urandom_range(1, 64) * 4;
            4: st = -($urandom_range(1, 64) * 64);
            5: st = $urandom;
            6: st = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: st = 32'd64;
          endcase
        end
        rq = '{ACT_ACCESS, pc_pool[s], tbl_last[idx] + st, 1'b0};
        if ($urandom_range(0, 19) == 0) rq.addr = $urandom;
        issue_request(rq, 1'b0, '0);
        done_items++;
        eff = (reqs_reg == '0) ? 1 : (reqs_reg > 5'd16) ? 16 : int'(reqs_reg);
        n_comp = ($urandom_range(0, 99) < 75) ? eff : $urandom_range(0, eff + 2);
        repeat (n_comp) begin
          if ($urandom_range(0, 19) == 0) begin
            rq = '{ACT_ACCESS, $urandom, $urandom, 1'($urandom_range(0, 1))};
            issue_request(rq, 1'b0, '0);
          end
          rq = '{ACT_DONE, $urandom, $urandom, 1'($urandom_range(0, 1))};
          issue_request(rq, 1'b0, '0);
          done_items++;
        end
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    pf_rsp_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (due_prefetch_q.size() == 0) begin
        $display("%0t: unexpected result valid=%0b addr=%08h", $time,
                 rsp.prefetch_valid, rsp.prefetch_addr);
        errors++;
      end else begin
        want = due_prefetch_q.pop_front();
        n_checked++;
        if (rsp.prefetch_valid !== want.valid) begin
          $display("%0t: prefetch_valid expected %0b got %0b", $time,
                   want.valid, rsp.prefetch_valid);
          errors++;
        end
        if (rsp.prefetch_addr !== want.addr) begin
          $display("%0t: prefetch_addr expected %08h got %08h", $time,
                   want.addr, rsp.prefetch_addr);
          errors++;
        end
      end
    end
  end

  // response side: random stalls plus a single long hold-off in phase 5
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      rsp.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [BLOCK_W-1:0]       ph_bs   [N_PHASES];
    logic signed [ADDR_W-1:0] ph_thr  [N_PHASES];
    logic [REQS_W-1:0]        ph_reqs [N_PHASES];
    int                       ph_mode [N_PHASES];
    dir_row_t                 row;
    req.valid       = 1'b0;
    req.action      = ACT_ACCESS;
    req.access_pc   = '0;
    req.access_addr = '0;
    req.l1_hit      = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_BLOCK_SIZE;
    cfg_data        = '0;
    send_pct        = 0;

    for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
      tbl_pc[i]     = '0;
      tbl_stride[i] = '0;
      tbl_last[i]   = '0;
    end
    pf_busy    = 1'b0;
    pf_addr    = '0;
    pf_left    = '0;
    pf_trigger = '0;
    blk_reg    = BLOCK_SIZE_RST;
    thr_reg    = '0;
    reqs_reg   = REQS_RST;

    pc_pool[0] = 32'h0000_0000;
    pc_pool[1] = 32'hffff_ffff;
    pc_pool[2] = 32'h0000_0100;
    pc_pool[3] = 32'hffff_ff00;
    for (int i = 4; i < N_STREAMS; i++) pc_pool[i] = $urandom;
    pc_pool[N_STREAMS-1][7:0] = pc_pool[4][7:0];

    // phase 0 keeps the reset settings
    ph_bs = '{13'd64, 13'd1, 13'd4096, 13'd0, 13'd8191, 13'd128, 13'd0, 13'd0, 13'd0};
    ph_thr = '{32'sd0, 32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1, 32'sd16,
               32'sd0, 32'sd0, 32'sd0};
    ph_reqs = '{5'd4, 5'd1, 5'd16, 5'd0, 5'd31, 5'd8, 5'd0, 5'd0, 5'd0};
    ph_mode = '{0, 1, 2, 3, 1, 0, 2, 3, 0};
    for (int p = 6; p < N_PHASES; p++) begin
      ph_bs[p]   = BLOCK_W'($urandom_range(1, 4096));
      ph_thr[p]  = $signed($urandom_range(0, 512)) - 256;
      ph_reqs[p] = REQS_W'($urandom_range(1, 16));
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIR_ROWS[i];
      issue_request('{row.action, row.pc, row.addr, row.hit}, row.typed,
                    '{row.want_v, row.want_a});
    end

    for (int p = 0; p < N_PHASES; p++) begin
      if (p != 0) begin
        wait_drained();
        program_regs(ph_bs[p], ph_thr[p], ph_reqs[p]);
      end
      case (ph_mode[p])
        1: begin send_pct = 48; stall_pct <= 0; end
        2: begin send_pct = 0;  stall_pct <= 48; end
        3: begin send_pct = 12; stall_pct <= 12; end
        default: begin send_pct = 0; stall_pct <= 0; end
      endcase
      // pressure: receiver holds off while requests keep coming
      if (p == 5) hold_seq <= hold_seq + 1;
      run_traffic(PHASE_ITEMS);
    end

    wait_drained();
    repeat (2 * SETTLE) @(posedge clk);
    if (due_prefetch_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, due_prefetch_q.size());
      errors++;
    end
    $display("ran %0d requests over %0d register settings: %0d misses armed, %0d stride hits",
             n_requests, N_PHASES, n_armed, n_stride_hits);
    $display("checked %0d results, %0d run advances, %0d mismatches",
             n_checked, n_advances, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/rptsp_pkg.sv
hw/rtl/rptsp_if.sv
hw/rtl/rptsp_ram.sv
hw/rtl/rptsp_datapath.sv
hw/rtl/rptsp_ctrl.sv
hw/rtl/rpt_stride_prefetcher_core.sv
tb/rpt_stride_prefetcher_core_tb.sv
